FILE: hw/rtl/smf_pkg.sv
// shared widths, defaults and control bundle for the sample mode finder
package smf_pkg;

	localparam int SAMPLE_W = 8;
	localparam int CNT_W = 9;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	localparam int DEF_NUM_BINS = 256;
	localparam int DEF_MAX_SAMPLES = 256;

	// per-cycle control for the stage 1 beat
	typedef struct packed {
		logic acc;   // input beat taken this cycle
		logic adv;   // stage 1 beat leaves this cycle
		logic last;  // stage 1 beat closes the run
	} smf_ctl_t;

endpackage

FILE: hw/rtl/smf_hist.sv
// histogram counter memory with valid bits, bypass and saturating increment
module smf_hist import smf_pkg::*; #(
	parameter int NUM_BINS = DEF_NUM_BINS,
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	localparam int BIN_W = $clog2(NUM_BINS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  smf_ctl_t         ctl,
	input  logic [BIN_W-1:0] rd_idx,
	input  logic [BIN_W-1:0] idx_s1,
	input  logic             in_range_s1,
	output logic             grew,
	output logic [CNT_W-1:0] new_cnt
);

	localparam int CNT_CAP = (MAX_SAMPLES < CNT_MAX) ? MAX_SAMPLES : CNT_MAX;

	logic [CNT_W-1:0] mem_q [NUM_BINS];
	logic [CNT_W-1:0] rd_q;
	logic [NUM_BINS-1:0] vld_q;
	logic fwd_hit_q;
	logic [CNT_W-1:0] fwd_val_q;
	logic [CNT_W-1:0] cur_cnt;
	logic wr;
	logic clr;

	always_comb begin
		if (fwd_hit_q) begin
			cur_cnt = fwd_val_q;
		end else if (vld_q[idx_s1]) begin
			cur_cnt = rd_q;
		end else begin
			cur_cnt = '0;
		end
	end

	assign grew = in_range_s1 && (cur_cnt < CNT_W'(CNT_CAP));
	assign new_cnt = cur_cnt + CNT_W'(1);
	assign wr = ctl.adv && grew;
	assign clr = ctl.adv && ctl.last;

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			rd_q <= mem_q[rd_idx];
			fwd_val_q <= new_cnt;
		end
		if (wr) begin
			mem_q[idx_s1] <= new_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr) begin
				vld_q[idx_s1] <= 1'b1;
			end
			// same-cycle write to the address being read
			if (ctl.acc) begin
				fwd_hit_q <= wr && !clr && (rd_idx == idx_s1);
			end
		end
	end

endmodule

FILE: hw/rtl/smf_track.sv
// running leader tracker and result register
module smf_track import smf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  smf_ctl_t            ctl,
	input  logic [SAMPLE_W-1:0] sample_s1,
	input  logic                grew,
	input  logic [CNT_W-1:0]    new_cnt,
	input  logic                mode_ready,
	output logic                mode_valid,
	output logic [SAMPLE_W-1:0] mode_value,
	output logic [CNT_W-1:0]    mode_count
);

	logic [SAMPLE_W-1:0] best_bin_q;
	logic [CNT_W-1:0] best_count_q;
	logic [SAMPLE_W-1:0] nxt_bin;
	logic [CNT_W-1:0] nxt_count;
	logic out_valid_q;

	always_comb begin
		nxt_bin = best_bin_q;
		nxt_count = best_count_q;
		if (grew) begin
			if (sample_s1 == best_bin_q) begin
				nxt_count = new_cnt;
			end else if ((new_cnt > best_count_q) ||
					((new_cnt == best_count_q) && (sample_s1 < best_bin_q))) begin
				nxt_bin = sample_s1;
				nxt_count = new_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_bin_q <= '0;
			best_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.adv) begin
				if (ctl.last) begin
					best_bin_q <= '0;
					best_count_q <= '0;
				end else begin
					best_bin_q <= nxt_bin;
					best_count_q <= nxt_count;
				end
			end
			if (ctl.adv && ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (mode_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.last) begin
			mode_value <= nxt_bin;
			mode_count <= nxt_count;
		end
	end

	assign mode_valid = out_valid_q;

endmodule

FILE: hw/rtl/sample_mode_finder.sv
// sample_mode_finder: one-sample-per-cycle histogram mode of a marked run
// result beat: the last sample beat is registered in stage 1 and loads the result register as it leaves stage 1
// throughput: 1 sample per cycle while no closing sample waits; at most one histogram read and one write each cycle
// a closing sample beat waits while the previous result beat is still held
// reset: asynchronous, clears bin valid bits, leader and result valid at once
// reset needs no clearing pass; the histogram is emptied at the end of each run
module sample_mode_finder import smf_pkg::*; #(
	parameter int NUM_BINS = DEF_NUM_BINS,
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last_sample,
	output logic                mode_valid,
	input  logic                mode_ready,
	output logic [SAMPLE_W-1:0] mode_value,
	output logic [CNT_W-1:0]    mode_count
);

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int CNT_CAP = (MAX_SAMPLES < CNT_MAX) ? MAX_SAMPLES : CNT_MAX;

	logic valid_s1;
	logic last_s1;
	logic in_range_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	smf_ctl_t ctl;
	logic grew;
	logic [CNT_W-1:0] new_cnt;

	assign ctl.adv = valid_s1 && (!last_s1 || !mode_valid || mode_ready);
	assign ctl.last = last_s1;
	assign sample_ready = !valid_s1 || ctl.adv;
	assign ctl.acc = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			sample_s1 <= sample;
			last_s1 <= last_sample;
			in_range_s1 <= ({1'b0, sample} < (SAMPLE_W + 1)'(NUM_BINS));
		end
	end

	smf_hist #(
		.NUM_BINS(NUM_BINS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.rd_idx(sample[BIN_W-1:0]),
		.idx_s1(sample_s1[BIN_W-1:0]),
		.in_range_s1(in_range_s1),
		.grew(grew),
		.new_cnt(new_cnt)
	);

	smf_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.sample_s1(sample_s1),
		.grew(grew),
		.new_cnt(new_cnt),
		.mode_ready(mode_ready),
		.mode_valid(mode_valid),
		.mode_value(mode_value),
		.mode_count(mode_count)
	);

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mode_valid) |-> $past(valid_s1 && last_s1))
		else $error("result beat without a closing sample");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		mode_valid |-> (mode_count <= CNT_W'(CNT_CAP)))
		else $error("mode count above cap");

	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_valid && (mode_count == '0)) |-> (mode_value == '0))
		else $error("empty run with nonzero mode value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && last_s1 && mode_valid && !mode_ready))
		else $error("input stalled without a held result");

endmodule
